// ===== rtl/art_pkg.sv =====
// Shared constants, codes and controller/datapath types for the address region table.
package art_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int PAGE_BYTES  = 4096;

  localparam int ADDR_W   = 64;
  localparam int RIGHTS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int CMD_W    = 2;
  localparam int IDX_W    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int SCAN_W   = $clog2(MAX_REGIONS + 1);

  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_ALLOC,
    ST_SPLIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic scan_run;
    logic fail;
    logic alloc;
    logic split_write;
    logic clear_all;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    command_t cmd;
    logic     len_zero;
    logic     empty_range;
    logic     stop;
    logic     scan_done;
    logic     out_free;
  } dp_status_t;

endpackage

// ===== rtl/art_if.sv =====
// Request and response channel interfaces of the address region table.
interface art_req_if;
  logic                          valid;
  logic                          ready;
  logic [art_pkg::CMD_W-1:0]     command;
  logic [art_pkg::ADDR_W-1:0]    base_address;
  logic [art_pkg::ADDR_W-1:0]    length;
  logic [art_pkg::RIGHTS_W-1:0]  rights;

  modport source (output valid, command, base_address, length, rights, input ready);
  modport sink (input valid, command, base_address, length, rights, output ready);
endinterface

interface art_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic                          hit;
  logic [art_pkg::RIGHTS_W-1:0]  hit_rights;
  logic [art_pkg::ADDR_W-1:0]    hit_start;
  logic [art_pkg::ADDR_W-1:0]    hit_end;
  logic [art_pkg::COUNT_W-1:0]   active_regions;

  modport source (output valid, ok, hit, hit_rights, hit_start, hit_end, active_regions,
                  input ready);
  modport sink (input valid, ok, hit, hit_rights, hit_start, hit_end, active_regions,
                output ready);
endinterface

// ===== rtl/address_region_table.sv =====
// Top level of the address region table: one request in flight, one response each.
// Steps: add/remove/lookup go through capture, alignment, a scan of one entry per cycle
// through the table memory read port, then for add or remove at most one allocation or
// split write, before the response; clear goes through capture and a table clear.
// Throughput: one request at a time; the next is accepted once the response is registered.
// Reset (synchronous, rst high) empties the table and count at once; no clearing pass.
module address_region_table (
  input logic      clk,
  input logic      rst,
  art_req_if.sink  req,
  art_rsp_if.source rsp
);

  art_pkg::ctrl_cmd_t  ctl;
  art_pkg::dp_status_t status;

  art_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .ctl      (ctl)
  );

  art_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .status             (status),
    .req_command        (req.command),
    .req_base_address   (req.base_address),
    .req_length         (req.length),
    .req_rights         (req.rights),
    .rsp_ready          (rsp.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ok             (rsp.ok),
    .rsp_hit            (rsp.hit),
    .rsp_hit_rights     (rsp.hit_rights),
    .rsp_hit_start      (rsp.hit_start),
    .rsp_hit_end        (rsp.hit_end),
    .rsp_active_regions (rsp.active_regions)
  );

endmodule

// ===== rtl/art_ctrl.sv =====
// Sequencing state machine of the address region table.
module art_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  art_pkg::dp_status_t status,
  output art_pkg::ctrl_cmd_t  ctl
);

  art_pkg::state_t state;
  art_pkg::state_t state_next;

  logic is_add;
  logic is_remove;
  logic len_skip;

  assign is_add    = (status.cmd == art_pkg::CMD_ADD);
  assign is_remove = (status.cmd == art_pkg::CMD_REMOVE);
  assign len_skip  = (is_add || is_remove) && status.len_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= art_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      art_pkg::ST_IDLE: begin
        if (in_valid) state_next = art_pkg::ST_PREP;
      end
      art_pkg::ST_PREP: begin
        if (status.cmd == art_pkg::CMD_CLEAR) state_next = art_pkg::ST_FINISH;
        else state_next = art_pkg::ST_SCAN;
      end
      art_pkg::ST_SCAN: begin
        if (len_skip) begin
          state_next = art_pkg::ST_FINISH;
        end else if (is_add && status.empty_range) begin
          state_next = art_pkg::ST_FINISH;
        end else if (status.stop) begin
          state_next = is_remove ? art_pkg::ST_SPLIT : art_pkg::ST_FINISH;
        end else if (status.scan_done) begin
          state_next = is_add ? art_pkg::ST_ALLOC : art_pkg::ST_FINISH;
        end
      end
      art_pkg::ST_ALLOC: state_next = art_pkg::ST_FINISH;
      art_pkg::ST_SPLIT: state_next = art_pkg::ST_FINISH;
      art_pkg::ST_FINISH: begin
        if (status.out_free) state_next = art_pkg::ST_IDLE;
      end
      default: state_next = art_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      art_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      art_pkg::ST_PREP: begin
        ctl.prep      = 1'b1;
        ctl.clear_all = (status.cmd == art_pkg::CMD_CLEAR);
      end
      art_pkg::ST_SCAN: begin
        ctl.scan_run = 1'b1;
        ctl.fail     = is_add && !status.len_zero && status.empty_range;
      end
      art_pkg::ST_ALLOC:  ctl.alloc = 1'b1;
      art_pkg::ST_SPLIT:  ctl.split_write = 1'b1;
      art_pkg::ST_FINISH: ctl.finish = status.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

// ===== rtl/art_datapath.sv =====
// Region storage, scan pipeline, compare logic and response register of the table.
module art_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  art_pkg::ctrl_cmd_t                  ctl,
  output art_pkg::dp_status_t                 status,
  input  logic [art_pkg::CMD_W-1:0]           req_command,
  input  logic [art_pkg::ADDR_W-1:0]          req_base_address,
  input  logic [art_pkg::ADDR_W-1:0]          req_length,
  input  logic [art_pkg::RIGHTS_W-1:0]        req_rights,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic                                rsp_ok,
  output logic                                rsp_hit,
  output logic [art_pkg::RIGHTS_W-1:0]        rsp_hit_rights,
  output logic [art_pkg::ADDR_W-1:0]          rsp_hit_start,
  output logic [art_pkg::ADDR_W-1:0]          rsp_hit_end,
  output logic [art_pkg::COUNT_W-1:0]         rsp_active_regions
);

  // Region table: start, end and rights live in memories; the active marks are flops.
  logic [art_pkg::ADDR_W-1:0]   start_mem  [art_pkg::MAX_REGIONS];
  logic [art_pkg::ADDR_W-1:0]   end_mem    [art_pkg::MAX_REGIONS];
  logic [art_pkg::RIGHTS_W-1:0] rights_mem [art_pkg::MAX_REGIONS];
  logic [art_pkg::MAX_REGIONS-1:0] active;
  logic [art_pkg::COUNT_W-1:0]     count;

  // Captured request.
  art_pkg::command_t            cmd_q;
  logic [art_pkg::ADDR_W-1:0]   base_q;
  logic [art_pkg::ADDR_W-1:0]   len_q;
  logic [art_pkg::RIGHTS_W-1:0] rights_q;
  logic [art_pkg::ADDR_W-1:0]   lo;
  logic [art_pkg::ADDR_W-1:0]   hi;
  logic                         len_zero;

  // Scan pipeline: one entry read per cycle, evaluated the cycle after.
  logic [art_pkg::SCAN_W-1:0]   issue_cnt;
  logic [art_pkg::IDX_W-1:0]    issue_idx;
  logic                         issue_en;
  logic                         ev_valid;
  logic [art_pkg::IDX_W-1:0]    ev_idx;
  logic [art_pkg::ADDR_W-1:0]   rd_start;
  logic [art_pkg::ADDR_W-1:0]   rd_end;
  logic [art_pkg::RIGHTS_W-1:0] rd_rights;

  logic [art_pkg::ADDR_W-1:0]   split_end;
  logic [art_pkg::RIGHTS_W-1:0] split_rights;

  logic                         ok_flag;
  logic                         hit_flag;
  logic [art_pkg::RIGHTS_W-1:0] hit_rights_q;
  logic [art_pkg::ADDR_W-1:0]   hit_start_q;
  logic [art_pkg::ADDR_W-1:0]   hit_end_q;

  logic                         eval_en;
  logic                         ev_act;
  logic                         add_end;
  logic                         add_start;
  logic                         rm_ov;
  logic                         cover_lo;
  logic                         cover_hi;
  logic                         rm_covered;
  logic                         rm_trim_lo;
  logic                         rm_trim_hi;
  logic                         rm_split;
  logic                         lk_hit;
  logic                         any_free;
  logic [art_pkg::IDX_W-1:0]    free_idx;
  logic                         new_entry;

  logic                         we_start;
  logic                         we_end;
  logic                         we_rights;
  logic [art_pkg::IDX_W-1:0]    w_idx;
  logic [art_pkg::ADDR_W-1:0]   w_start;
  logic [art_pkg::ADDR_W-1:0]   w_end;
  logic [art_pkg::RIGHTS_W-1:0] w_rights;

  function automatic logic [art_pkg::IDX_W-1:0] lowest_free(
    input logic [art_pkg::MAX_REGIONS-1:0] act
  );
    logic [art_pkg::IDX_W-1:0] idx;
    idx = '0;
    for (int i = art_pkg::MAX_REGIONS - 1; i >= 0; i--) begin
      if (!act[i]) idx = art_pkg::IDX_W'(i);
    end
    return idx;
  endfunction

  assign issue_idx = issue_cnt[art_pkg::IDX_W-1:0];
  assign issue_en  = ctl.scan_run && (issue_cnt < art_pkg::SCAN_W'(art_pkg::MAX_REGIONS));

  assign any_free  = ~&active;
  assign free_idx  = lowest_free(active);
  assign new_entry = (ctl.alloc || ctl.split_write) && any_free;

  // Per-entry decisions on the entry read in the previous cycle.
  assign eval_en = ctl.scan_run && ev_valid;
  assign ev_act  = active[ev_idx];

  assign add_end   = eval_en && (cmd_q == art_pkg::CMD_ADD) && ev_act &&
                     (rd_end == lo) && (rd_rights == rights_q);
  assign add_start = eval_en && (cmd_q == art_pkg::CMD_ADD) && ev_act && !add_end &&
                     (rd_start == hi) && (rd_rights == rights_q);

  assign rm_ov      = eval_en && (cmd_q == art_pkg::CMD_REMOVE) && ev_act &&
                      !(lo >= rd_end) && !(hi <= rd_start);
  assign cover_lo   = (lo <= rd_start);
  assign cover_hi   = (hi >= rd_end);
  assign rm_covered = rm_ov && cover_lo && cover_hi;
  assign rm_trim_lo = rm_ov && cover_lo && !cover_hi;
  assign rm_trim_hi = rm_ov && !cover_lo && cover_hi;
  assign rm_split   = rm_ov && !cover_lo && !cover_hi;

  assign lk_hit = eval_en && (cmd_q == art_pkg::CMD_LOOKUP) && ev_act &&
                  (base_q >= rd_start) && (base_q < rd_end);

  // Single write port shared by scan updates and new-entry allocation.
  always_comb begin
    w_idx     = new_entry ? free_idx : ev_idx;
    we_start  = add_start || rm_trim_lo || new_entry;
    we_end    = add_end || rm_trim_hi || rm_split || new_entry;
    we_rights = new_entry;
    w_start   = add_start ? lo : hi;
    if (ctl.split_write) begin
      w_start  = hi;
      w_end    = split_end;
      w_rights = split_rights;
    end else if (ctl.alloc) begin
      w_start  = lo;
      w_end    = hi;
      w_rights = rights_q;
    end else begin
      w_end    = add_end ? hi : lo;
      w_rights = rights_q;
    end
  end

  always_ff @(posedge clk) begin
    if (we_start)  start_mem[w_idx]  <= w_start;
    if (we_end)    end_mem[w_idx]    <= w_end;
    if (we_rights) rights_mem[w_idx] <= w_rights;
    if (issue_en) begin
      rd_start  <= start_mem[issue_idx];
      rd_end    <= end_mem[issue_idx];
      rd_rights <= rights_mem[issue_idx];
      ev_idx    <= issue_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      count     <= '0;
      issue_cnt <= '0;
      ev_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.clear_all) begin
        active <= '0;
        count  <= '0;
      end else if (rm_covered) begin
        active[ev_idx] <= 1'b0;
        if (count != '0) count <= count - 1'b1;
      end else if (new_entry) begin
        active[free_idx] <= 1'b1;
        count            <= count + 1'b1;
      end

      if (ctl.prep) begin
        issue_cnt <= '0;
        ev_valid  <= 1'b0;
      end else begin
        ev_valid <= issue_en;
        if (issue_en) issue_cnt <= issue_cnt + 1'b1;
      end

      if (ctl.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture, page alignment and per-request results.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q        <= art_pkg::command_t'(req_command);
      base_q       <= req_base_address;
      len_q        <= req_length;
      rights_q     <= req_rights;
      ok_flag      <= 1'b1;
      hit_flag     <= 1'b0;
      hit_rights_q <= '0;
      hit_start_q  <= '0;
      hit_end_q    <= '0;
    end
    if (ctl.prep) begin
      lo       <= base_q & ~art_pkg::PAGE_MASK;
      hi       <= (base_q + len_q + art_pkg::PAGE_MASK) & ~art_pkg::PAGE_MASK;
      len_zero <= (len_q == '0);
    end
    if (ctl.fail || (ctl.alloc && !any_free)) ok_flag <= 1'b0;
    if (lk_hit) begin
      hit_flag     <= 1'b1;
      hit_rights_q <= rd_rights;
      hit_start_q  <= rd_start;
      hit_end_q    <= rd_end;
    end
    if (rm_split) begin
      split_end    <= rd_end;
      split_rights <= rd_rights;
    end
    if (ctl.finish) begin
      rsp_ok             <= ok_flag;
      rsp_hit            <= hit_flag;
      rsp_hit_rights     <= hit_rights_q;
      rsp_hit_start      <= hit_start_q;
      rsp_hit_end        <= hit_end_q;
      rsp_active_regions <= count;
    end
  end

  always_comb begin
    status.cmd         = cmd_q;
    status.len_zero    = len_zero;
    status.empty_range = (hi <= lo);
    status.stop        = add_end || add_start || rm_split || lk_hit;
    status.scan_done   = ev_valid && (ev_idx == art_pkg::IDX_W'(art_pkg::MAX_REGIONS - 1));
    status.out_free    = !rsp_valid || rsp_ready;
  end

endmodule
